[sv/rnc_pkg.sv]
// Shared types, widths and codes for the rotational network coupling block.
// No dependencies; every other file of the block except rnc_ram imports this package.
package rnc_pkg;

  // Network size and the index widths that follow from it.
  localparam int NODES   = 64;
  localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WADDR_W = 2 * IDX_W;
  localparam int WDEPTH  = 2 ** WADDR_W;

  // Datapath widths.
  localparam int DIFF_W  = 17;               // Q4.12 difference
  localparam int PROD_W  = 33;               // Q1.14 times difference
  localparam int ROT_W   = 34;               // rotated difference, Q.26
  localparam int MAC_W   = 50;               // weight times rotated difference, Q.40
  localparam int ACC_W   = MAC_W + IDX_W;    // sum over all nodes
  localparam int RND_W   = ACC_W - 16;       // accumulator rounded to Q.24
  localparam int GPROD_W = RND_W + 17;       // times unsigned Q8.8 gain, Q.32
  localparam int FIN_W   = GPROD_W - 20;     // rounded to Q.12 before saturation

  // Number of register stages from RAM read to accumulator.
  localparam int PIPE_D = 5;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [WADDR_W-1:0] waddr_t;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_STATE   = 2'd0,
    OP_WEIGHT  = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_COS    = 2'd0,
    REG_SIN    = 2'd1,
    REG_GAIN_U = 2'd2,
    REG_GAIN_V = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [15:0] COS_RESET  = 16'd16384;
  localparam logic [15:0] SIN_RESET  = 16'd0;
  localparam logic [15:0] GAIN_RESET = 16'd256;

  // Controls from the sequencer to the multiply-accumulate pipeline.
  typedef struct packed {
    logic clear;    // zero the accumulators
    logic xi_load;  // node RAM output holds the center node state
    logic issue;    // a neighbor read was issued this cycle
  } mac_ctrl_t;

  // Controls from the sequencer to the gain and rounding stage.
  typedef struct packed {
    logic rnd_en;   // round accumulators to Q.24
    logic mul_en;   // multiply by gains
  } fin_ctrl_t;

endpackage

[sv/rnc_req_if.sv]
// Request channel of the rotational network coupling block.
// Depends on rnc_pkg for nothing but shared style; payload widths are fixed.
interface rnc_req_if import rnc_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  row_node;
  logic [5:0]  col_node;
  logic [15:0] state_u;
  logic [15:0] state_v;
  logic [15:0] weight;

  modport source (
    output valid, opcode, row_node, col_node, state_u, state_v, weight,
    input  ready
  );
  modport sink (
    input  valid, opcode, row_node, col_node, state_u, state_v, weight,
    output ready
  );
endinterface

[sv/rnc_rsp_if.sv]
// Result channel of the rotational network coupling block.
// Imports rnc_pkg; carries the saturated coupling terms and flag.
interface rnc_rsp_if import rnc_pkg::*;;
  logic        valid;
  logic        ready;
  logic [31:0] coupling_u;
  logic [31:0] coupling_v;
  logic        saturated;

  modport source (
    output valid, coupling_u, coupling_v, saturated,
    input  ready
  );
  modport sink (
    input  valid, coupling_u, coupling_v, saturated,
    output ready
  );
endinterface

[sv/rnc_cfg_if.sv]
// Configuration write channel of the rotational network coupling block.
// Register indexes follow cfg_reg_t in rnc_pkg.
interface rnc_cfg_if import rnc_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[sv/rotational_network_coupling.sv]
// Rotational network coupling: top level with sequencer, registers and RAMs.
// Depends on rnc_pkg, the rnc_*_if interfaces, rnc_ram, rnc_mac, rnc_finish.
//
// Usage. Requests arrive on req. A state request (OP_STATE) stores the
// state_u and state_v of node row_node; a weight request (OP_WEIGHT) stores
// the weight of row row_node, column col_node. Both store when taken and give
// no result. A compute request (OP_COMPUTE) walks all NODES neighbors of node
// row_node and returns one result on rsp: the coupling terms scaled by
// gain_u and gain_v, saturated to 32 bits, with a flag for any clip.
// Requests naming a node at or beyond NODES, and unknown opcodes, are
// dropped. Configuration writes on cfg set cos_phi, sin_phi, gain_u and
// gain_v; they are taken at any cycle and must only be made while idle.
// Sequence: a compute request occupies the block for one node RAM read per
// neighbor, a drain of the five pipeline stages, then rounding, gain and
// result stages; its result appears on rsp at the edge where the block turns
// ready again. The block stays ready through load requests.
// If rsp stalls, the block keeps taking requests; a later compute holds its
// result in the sequencer, taking no request, until the earlier one is taken.
// Reset restores the register defaults and empties the pipeline; the RAM
// contents are undefined until written.
module rotational_network_coupling import rnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rnc_cfg_if.sink     cfg,
  rnc_req_if.sink     req,
  rnc_rsp_if.source   rsp
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_RND   = 6'b001000,
    S_MUL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic signed [15:0] cos_phi, sin_phi;
  logic [15:0]        gain_u, gain_v;

  logic               accept, row_ok, col_ok, start;
  idx_t               row_idx, col_idx, row_q, cnt;
  logic               xi_load;

  logic               node_we;
  idx_t               node_raddr;
  logic [31:0]        node_rdata;
  logic               wgt_we;
  waddr_t             wgt_waddr, wgt_raddr;
  logic [15:0]        wgt_rdata;

  mac_ctrl_t                mac_ctrl;
  fin_ctrl_t                fin_ctrl;
  logic signed [ACC_W-1:0]  acc_u, acc_v;
  logic                     mac_busy;
  logic [31:0]              fin_u, fin_v;
  logic                     fin_sat;
  logic                     rsp_load;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_phi <= COS_RESET;
      sin_phi <= SIN_RESET;
      gain_u  <= GAIN_RESET;
      gain_v  <= GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_COS:    cos_phi <= cfg.data;
        REG_SIN:    sin_phi <= cfg.data;
        REG_GAIN_U: gain_u  <= cfg.data;
        REG_GAIN_V: gain_v  <= cfg.data;
        default:    ;
      endcase
    end
  end

  // Request decode.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign row_ok    = int'(req.row_node) < NODES;
  assign col_ok    = int'(req.col_node) < NODES;
  assign row_idx   = idx_t'(req.row_node);
  assign col_idx   = idx_t'(req.col_node);
  assign start     = accept && row_ok && (req.opcode == OP_COMPUTE);

  // Node state RAM: written by state requests, read for center then neighbors.
  assign node_we    = accept && row_ok && (req.opcode == OP_STATE);
  assign node_raddr = (state == S_WALK) ? cnt : row_idx;

  rnc_ram #(
    .WIDTH (32),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (row_idx),
    .wdata ({req.state_u, req.state_v}),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Coupling weight RAM: row-major, one row per center node.
  assign wgt_we    = accept && row_ok && col_ok && (req.opcode == OP_WEIGHT);
  assign wgt_waddr = {row_idx, col_idx};
  assign wgt_raddr = {row_q, cnt};

  rnc_ram #(
    .WIDTH (16),
    .DEPTH (WDEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (req.weight),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_WALK;
      S_WALK:  if (cnt == idx_t'(NODES - 1)) state_next = S_DRAIN;
      S_DRAIN: if (!mac_busy) state_next = S_RND;
      S_RND:   state_next = S_MUL;
      S_MUL:   state_next = S_DONE;
      S_DONE:  if (rsp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      xi_load <= 1'b0;
    end else begin
      state   <= state_next;
      xi_load <= start;
    end
  end

  // Center row and neighbor counter.
  always_ff @(posedge clk) begin
    if (start) begin
      row_q <= row_idx;
      cnt   <= '0;
    end else if (state == S_WALK) begin
      cnt   <= cnt + idx_t'(1);
    end
  end

  // Multiply-accumulate pipeline.
  assign mac_ctrl.clear   = start;
  assign mac_ctrl.xi_load = xi_load;
  assign mac_ctrl.issue   = (state == S_WALK);

  rnc_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mac_ctrl),
    .node_rdata   (node_rdata),
    .weight_rdata (wgt_rdata),
    .cos_phi      (cos_phi),
    .sin_phi      (sin_phi),
    .acc_u        (acc_u),
    .acc_v        (acc_v),
    .busy         (mac_busy)
  );

  // Gain, rounding and saturation.
  assign fin_ctrl.rnd_en = (state == S_RND);
  assign fin_ctrl.mul_en = (state == S_MUL);

  rnc_finish u_finish (
    .clk        (clk),
    .ctrl       (fin_ctrl),
    .acc_u      (acc_u),
    .acc_v      (acc_v),
    .gain_u     (gain_u),
    .gain_v     (gain_v),
    .coupling_u (fin_u),
    .coupling_v (fin_v),
    .saturated  (fin_sat)
  );

  // Result register; a new result loads once the previous one is taken.
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.coupling_u <= fin_u;
      rsp.coupling_v <= fin_v;
      rsp.saturated  <= fin_sat;
    end
  end

endmodule

[sv/rnc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rnc_mac.sv]
// Neighbor pipeline: state difference, rotation, weighting and accumulation.
// Depends on rnc_pkg; fed by the node and weight RAM read ports.
module rnc_mac import rnc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic [31:0]             node_rdata,
  input  logic [15:0]             weight_rdata,
  input  logic signed [15:0]      cos_phi,
  input  logic signed [15:0]      sin_phi,
  output logic signed [ACC_W-1:0] acc_u,
  output logic signed [ACC_W-1:0] acc_v,
  output logic                    busy
);

  logic [PIPE_D-1:0]         vld;
  logic signed [15:0]        xi_u, xi_v;
  logic signed [15:0]        uj, vj, wj;
  logic signed [DIFF_W-1:0]  du, dv;
  logic signed [DIFF_W-1:0]  du_next, dv_next;
  logic signed [15:0]        w_d, w_p, w_r;
  logic signed [PROD_W-1:0]  p_cu, p_sv, p_cv, p_su;
  logic signed [PROD_W-1:0]  p_cu_next, p_sv_next, p_cv_next, p_su_next;
  logic signed [ROT_W-1:0]   ru, rv;
  logic signed [MAC_W-1:0]   m_u, m_v;

  assign uj = node_rdata[31:16];
  assign vj = node_rdata[15:0];
  assign wj = weight_rdata;

  // Valid bits follow each issued read down the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_D-2:0], ctrl.issue};
    end
  end

  assign busy = |vld;

  // Center node state arrives in the cycle after the compute request is taken.
  always_ff @(posedge clk) begin
    if (ctrl.xi_load) begin
      xi_u <= uj;
      xi_v <= vj;
    end
  end

  // Difference of neighbor and center state.
  always_comb begin
    du_next = DIFF_W'(uj) - DIFF_W'(xi_u);
    dv_next = DIFF_W'(vj) - DIFF_W'(xi_v);
  end

  // Rotation partial products.
  always_comb begin
    p_cu_next = PROD_W'(cos_phi) * PROD_W'(du);
    p_sv_next = PROD_W'(sin_phi) * PROD_W'(dv);
    p_cv_next = PROD_W'(cos_phi) * PROD_W'(dv);
    p_su_next = PROD_W'(sin_phi) * PROD_W'(du);
  end

  // Data stages; the weight travels alongside to meet its rotated difference.
  always_ff @(posedge clk) begin
    du   <= du_next;
    dv   <= dv_next;
    w_d  <= wj;
    p_cu <= p_cu_next;
    p_sv <= p_sv_next;
    p_cv <= p_cv_next;
    p_su <= p_su_next;
    w_p  <= w_d;
    ru   <= ROT_W'(p_cu) + ROT_W'(p_sv);
    rv   <= ROT_W'(p_cv) - ROT_W'(p_su);
    w_r  <= w_p;
    m_u  <= MAC_W'(w_r) * MAC_W'(ru);
    m_v  <= MAC_W'(w_r) * MAC_W'(rv);
  end

  // Accumulators, cleared at the start of each compute request.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_u <= '0;
      acc_v <= '0;
    end else if (vld[PIPE_D-1]) begin
      acc_u <= acc_u + ACC_W'(m_u);
      acc_v <= acc_v + ACC_W'(m_v);
    end
  end

endmodule

[sv/rnc_finish.sv]
// Output scaling: round the sums, apply the gains, round and saturate.
// Depends on rnc_pkg; takes the accumulators of rnc_mac.
module rnc_finish import rnc_pkg::*; (
  input  logic                    clk,
  input  fin_ctrl_t               ctrl,
  input  logic signed [ACC_W-1:0] acc_u,
  input  logic signed [ACC_W-1:0] acc_v,
  input  logic [15:0]             gain_u,
  input  logic [15:0]             gain_v,
  output logic [31:0]             coupling_u,
  output logic [31:0]             coupling_v,
  output logic                    saturated
);

  localparam logic signed [ACC_W-1:0]   HALF_ACC = ACC_W'(32768);
  localparam logic signed [GPROD_W-1:0] HALF_GP  = GPROD_W'(524288);
  localparam logic signed [FIN_W-1:0]   SAT_HI   = FIN_W'(32'sh7fffffff);
  localparam logic signed [FIN_W-1:0]   SAT_LO   = FIN_W'(32'sh80000000);

  logic signed [ACC_W-1:0]   sum_u, sum_v;
  logic signed [RND_W-1:0]   rnd_u, rnd_v;
  logic signed [GPROD_W-1:0] gp_u, gp_v;
  logic signed [GPROD_W-1:0] gsum_u, gsum_v;
  logic signed [FIN_W-1:0]   f_u, f_v;
  logic [32:0]               s_u, s_v;

  // Clip to the signed 32-bit range; the top bit flags a clip.
  function automatic logic [32:0] sat32(input logic signed [FIN_W-1:0] x);
    logic [32:0] r;
    if (x > SAT_HI) begin
      r = {1'b1, 32'h7fffffff};
    end else if (x < SAT_LO) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  // Round half up from Q.40 to Q.24.
  assign sum_u = acc_u + HALF_ACC;
  assign sum_v = acc_v + HALF_ACC;

  always_ff @(posedge clk) begin
    if (ctrl.rnd_en) begin
      rnd_u <= RND_W'(sum_u >>> 16);
      rnd_v <= RND_W'(sum_v >>> 16);
    end
  end

  // Gain multiply; the gains are unsigned and zero-extended.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      gp_u <= GPROD_W'(rnd_u) * GPROD_W'($signed({1'b0, gain_u}));
      gp_v <= GPROD_W'(rnd_v) * GPROD_W'($signed({1'b0, gain_v}));
    end
  end

  // Round half up from Q.32 to Q.12, then saturate.
  always_comb begin
    gsum_u = gp_u + HALF_GP;
    gsum_v = gp_v + HALF_GP;
    f_u    = FIN_W'(gsum_u >>> 20);
    f_v    = FIN_W'(gsum_v >>> 20);
    s_u    = sat32(f_u);
    s_v    = sat32(f_v);
  end

  assign coupling_u = s_u[31:0];
  assign coupling_v = s_v[31:0];
  assign saturated  = s_u[32] | s_v[32];

endmodule
